### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the pool allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### sv/tpa_pkg.sv
// ----------------------------------------------------------------------------
// Timed pool allocator package
// Field widths, payload structs and the scan token shared by the cell row.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int NUM_UNITS_DEF = 128;

    localparam int TIME_W = 20;
    localparam int WANT_W = 8;
    localparam int HOLD_W = 10;
    localparam int FREE_W = 21;
    localparam int SUM_W  = 14;
    localparam int CFG_W  = 8;

    // Wide enough to count up to 2047 units, more than the 255 that the active count allows.
    localparam int CNT_W  = 11;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 8'd128;

    typedef struct packed {
        logic [TIME_W-1:0] request_time;
        logic [WANT_W-1:0] units_wanted;
        logic [HOLD_W-1:0] hold_time;
    } in_t;

    typedef struct packed {
        logic             granted;
        logic [SUM_W-1:0] id_sum;
    } out_t;

    typedef struct packed {
        logic             valid;
        logic             grant;
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
    } tok_t;

endpackage

### sv/tpa_cell.sv
// ----------------------------------------------------------------------------
// Pool allocator cell
// Holds the free time of one unit and updates the scan token passing through.
// ----------------------------------------------------------------------------
module tpa_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tpa_pkg::tok_t              tok_in,
    output tpa_pkg::tok_t              tok_out,
    input  logic [tpa_pkg::TIME_W-1:0] now,
    input  logic [tpa_pkg::FREE_W-1:0] busy_end,
    input  logic [tpa_pkg::WANT_W-1:0] want,
    input  logic [tpa_pkg::CFG_W-1:0]  active_units
);
    import tpa_pkg::*;

    logic [FREE_W-1:0] free_at_reg;
    logic [FREE_W-1:0] free_at_next;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic              active;
    logic              is_free;
    logic              take;

    assign active  = CNT_W'(CELL_IDX) < CNT_W'(active_units);
    assign is_free = active && (free_at_reg <= FREE_W'(now));
    assign take    = tok_in.valid && tok_in.grant && is_free && (tok_in.cnt < CNT_W'(want));

    always_comb
    begin
        tok_next     = tok_in;
        free_at_next = free_at_reg;
        if (tok_in.valid && !tok_in.grant && is_free)
        begin
            tok_next.cnt = tok_in.cnt + CNT_W'(1);
        end
        if (take)
        begin
            tok_next.cnt = tok_in.cnt + CNT_W'(1);
            tok_next.sum = tok_in.sum + SUM_W'(CELL_IDX + 1);
            free_at_next = busy_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_at_reg <= '0;
            tok_reg     <= '0;
        end
        else
        begin
            free_at_reg <= free_at_next;
            tok_reg     <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### sv/timed_pool_allocator.sv
// ----------------------------------------------------------------------------
// Timed pool allocator
// Grants the lowest-numbered free units of a pool whose units carry busy timers.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Direction   Content
//  in        in_valid, in_ready, in_data      to block    request (in_t)
//  out       out_valid, out_ready, out_data   from block  grant result (out_t)
//  cfg       cfg_valid, cfg_ready, cfg_data   to block    active unit count
//
// A token walks the cell row one cell per clock, once to count free units and,
// if enough are free, once more to grant them.
// Reset marks every unit free and sets the active count to 128.
// The result sits in an output register, so a new request is taken while it
// waits; a finished scan holds its result until that register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_pool_allocator #(
    parameter int NUM_UNITS = tpa_pkg::NUM_UNITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  tpa_pkg::in_t              in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output tpa_pkg::out_t             out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tpa_pkg::CFG_W-1:0] cfg_data
);
    import tpa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_COUNT = 4'b0010,
        S_GRANT = 4'b0100,
        S_WAIT  = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CFG_W-1:0]  active_units_reg;
    logic [TIME_W-1:0] now_reg;
    logic [FREE_W-1:0] until_reg;
    logic [WANT_W-1:0] want_reg;
    tok_t              inj_reg;
    tok_t              inj_next;
    out_t              res_reg;
    out_t              res_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_t              out_data_reg;
    out_t              out_data_next;
    tok_t              chain [NUM_UNITS+1];
    logic [NUM_UNITS-1:0] tok_valid_vec;
    tok_t              end_tok;
    logic              in_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign chain[0]  = inj_reg;
    assign end_tok   = chain[NUM_UNITS];

    for (genvar g = 0; g < NUM_UNITS; g++)
    begin : g_cell
        tpa_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .tok_in       (chain[g]),
            .tok_out      (chain[g+1]),
            .now          (now_reg),
            .busy_end     (until_reg),
            .want         (want_reg),
            .active_units (active_units_reg)
        );
        assign tok_valid_vec[g] = chain[g+1].valid;
    end

    always_comb
    begin
        state_next     = state_reg;
        inj_next       = '0;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    inj_next.valid = 1'b1;
                    state_next     = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (end_tok.valid)
                begin
                    if (end_tok.cnt < CNT_W'(want_reg))
                    begin
                        res_next   = '0;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        inj_next.valid = 1'b1;
                        inj_next.grant = 1'b1;
                        state_next     = S_GRANT;
                    end
                end
            end
            S_GRANT:
            begin
                if (end_tok.valid)
                begin
                    res_next.granted = 1'b1;
                    res_next.id_sum  = end_tok.sum;
                    state_next       = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            active_units_reg <= ACTIVE_RESET;
            inj_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_reg       <= inj_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                active_units_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        if (in_fire)
        begin
            now_reg   <= in_data.request_time;
            want_reg  <= in_data.units_wanted;
            until_reg <= FREE_W'(in_data.request_time) + FREE_W'(in_data.hold_time);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_CLK(a_one_token, clk, rst_n, $onehot0(tok_valid_vec), "more than one scan token in the cell row")
    `ASSERT_CLK(a_idle_empty, clk, rst_n, in_ready |-> (tok_valid_vec == '0) && !inj_reg.valid, "scan token present while idle")
    `ASSERT_NEVER(a_end_state, clk, rst_n, end_tok.valid && !(state_reg == S_COUNT || state_reg == S_GRANT), "scan token ended outside a scan")
    `ASSERT_NEVER(a_fail_sum, clk, rst_n, out_valid && !out_data.granted && (out_data.id_sum != '0), "refused request carries a nonzero id sum")
    `ASSERT_CLK(a_grant_pass, clk, rst_n, (state_reg == S_COUNT) && end_tok.valid && (end_tok.cnt >= CNT_W'(want_reg)) |=> inj_reg.valid && inj_reg.grant, "grant pass not launched after a successful count")

endmodule

### test/tb_timed_pool_allocator.sv
// ----------------------------------------------------------------------------
// Timed pool allocator testbench
// Sends requests over the valid/ready input channel, predicts every grant
// result from a local model of the unit timers and the active count, and
// checks each output transfer against the oldest prediction. The active count
// is rewritten between phases, and the handshakes idle at several rates.
// ----------------------------------------------------------------------------
module tb_timed_pool_allocator;
    import tpa_pkg::*;

    localparam int UNITS      = tpa_pkg::NUM_UNITS_DEF;
    localparam int IDLE_LIMIT = 5000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    tpa_pkg::in_t              in_data;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    tpa_pkg::out_t             out_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [tpa_pkg::CFG_W-1:0] cfg_data;

    logic [tpa_pkg::FREE_W-1:0] unit_free_at [UNITS];
    logic [tpa_pkg::CFG_W-1:0]  pool_count;
    tpa_pkg::out_t              grant_q [$];

    int err_count   = 0;
    int idle_cycles = 0;
    int in_idle     = 0;
    int out_stall   = 0;
    int now_t       = 0;

    timed_pool_allocator #(
        .NUM_UNITS(UNITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_stall);
    end

    function automatic tpa_pkg::out_t allocate_units(tpa_pkg::in_t r);
        tpa_pkg::out_t              res;
        int                         size;
        int                         n_free;
        int                         taken;
        int                         sum;
        logic [tpa_pkg::FREE_W-1:0] now_ext;
        logic [tpa_pkg::FREE_W-1:0] until_t;
        size    = (pool_count > UNITS) ? UNITS : int'(pool_count);
        now_ext = {1'b0, r.request_time};
        until_t = now_ext + FREE_W'(r.hold_time);
        n_free  = 0;
        res     = '0;
        for (int i = 0; i < size; i++)
        begin
            if (unit_free_at[i] <= now_ext)
                n_free++;
        end
        if (n_free >= int'(r.units_wanted))
        begin
            taken = 0;
            sum   = 0;
            for (int i = 0; i < size && taken < int'(r.units_wanted); i++)
            begin
                if (unit_free_at[i] <= now_ext)
                begin
                    unit_free_at[i] = until_t;
                    sum += i + 1;
                    taken++;
                end
            end
            res.granted = 1'b1;
            res.id_sum  = sum[tpa_pkg::SUM_W-1:0];
        end
        return res;
    endfunction

    // Result checker: every output transfer is matched with the oldest grant.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (grant_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: granted=%0d id_sum=%0d",
                             out_data.granted, out_data.id_sum);
            end
            else
            begin
                if (out_data.granted !== grant_q[0].granted ||
                    out_data.id_sum !== grant_q[0].id_sum)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected granted=%0d id_sum=%0d, got granted=%0d id_sum=%0d",
                                 grant_q[0].granted, grant_q[0].id_sum,
                                 out_data.granted, out_data.id_sum);
                end
                void'(grant_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [tpa_pkg::TIME_W-1:0] t,
                            input logic [tpa_pkg::WANT_W-1:0] want,
                            input logic [tpa_pkg::HOLD_W-1:0] hold);
        tpa_pkg::in_t r;
        r.request_time = t;
        r.units_wanted = want;
        r.hold_time    = hold;
        while ($urandom_range(99) < in_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        grant_q.insert(grant_q.size(), allocate_units(r));
        @(negedge clk);
    endtask

    task automatic pause_until_drained(input int extra);
        in_valid <= 1'b0;
        while (grant_q.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_pool_count(input logic [tpa_pkg::CFG_W-1:0] value);
        pause_until_drained(4);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        pool_count = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_basics();
        in_idle   = 26;
        out_stall = 26;
        send_req(20'd10, 8'd0, 10'd5);
        send_req(20'd10, 8'd1, 10'd0);
        send_req(20'd10, 8'd128, 10'd1023);
        send_req(20'd1032, 8'd1, 10'd1);
        send_req(20'd1033, 8'd128, 10'd1);
        send_req(20'd1034, 8'd255, 10'd7);
        send_req(20'd1034, 8'd0, 10'd1023);
        now_t = 1100;
    endtask

    task automatic test_pool_limits();
        write_pool_count(8'd1);
        send_req(TIME_W'(now_t), 8'd1, 10'd50);
        send_req(TIME_W'(now_t), 8'd1, 10'd50);
        send_req(TIME_W'(now_t), 8'd0, 10'd50);
        send_req(TIME_W'(now_t + 60), 8'd2, 10'd1);
        write_pool_count(8'd0);
        send_req(TIME_W'(now_t + 60), 8'd1, 10'd1);
        send_req(TIME_W'(now_t + 60), 8'd0, 10'd1);
        write_pool_count(8'd255);
        send_req(TIME_W'(now_t + 100), 8'd128, 10'd3);
        send_req(TIME_W'(now_t + 200), 8'd255, 10'd3);
        now_t += 200;
    endtask

    task automatic test_keep_times();
        write_pool_count(8'd3);
        send_req(TIME_W'(now_t), 8'd3, 10'd500);
        write_pool_count(8'd128);
        send_req(TIME_W'(now_t + 1), 8'd128, 10'd2);
        send_req(TIME_W'(now_t + 1), 8'd125, 10'd2);
        write_pool_count(8'd3);
        send_req(TIME_W'(now_t + 10), 8'd1, 10'd2);
        now_t += 600;
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct,
                                       input logic [tpa_pkg::CFG_W-1:0] count);
        int  roll;
        int  t;
        int  want;
        int  limit;
        write_pool_count(count);
        in_idle   = idle_pct;
        out_stall = stall_pct;
        limit     = (count > UNITS) ? UNITS : int'(count);
        for (int k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                t = now_t - int'($urandom_range(0, 3000));
                if (t < 0)
                    t = 0;
            end
            else
            begin
                if ($urandom_range(9) != 0)
                    now_t += $urandom_range(1, 48);
                t = now_t;
            end
            roll = $urandom_range(99);
            if (roll < 70)
                want = $urandom_range(0, 16);
            else if (roll < 90)
                want = $urandom_range(0, limit);
            else
                want = $urandom_range(0, 255);
            send_req(t[tpa_pkg::TIME_W-1:0], want[tpa_pkg::WANT_W-1:0],
                     HOLD_W'($urandom_range(0, 1023)));
            if ($urandom_range(39) == 0)
                pause_until_drained(1);
        end
    endtask

    task automatic test_time_ceiling();
        write_pool_count(8'd128);
        in_idle   = 0;
        out_stall = 0;
        send_req(20'hFFFFF, 8'd128, 10'd1023);
        send_req(20'hFFFFF, 8'd1, 10'd5);
        for (int k = 0; k < 20; k++)
            send_req(TIME_W'($urandom_range(0, 20'hFFFFF)), WANT_W'($urandom_range(0, 255)),
                     HOLD_W'($urandom_range(0, 1023)));
        send_req(20'd0, 8'd0, 10'd0);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        pool_count = tpa_pkg::ACTIVE_RESET;
        for (int i = 0; i < UNITS; i++)
            unit_free_at[i] = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_basics();
        test_pool_limits();
        test_keep_times();
        test_random_traffic(90, 0, 0, 8'd128);
        test_random_traffic(90, 86, 0, 8'd200);
        test_random_traffic(90, 0, 86, 8'd37);
        test_random_traffic(90, 26, 26, CFG_W'($urandom_range(1, 128)));
        test_time_ceiling();

        pause_until_drained(300);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
